// ===== hdl/owes_pkg.sv =====
// shared types, constants and command codes for the oriented window edge scorer
// no dependencies
`default_nettype none
package owes_pkg;

  localparam int COORD_BITS       = 12;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int ACC_BITS         = 40;

  localparam int PIX_BITS    = 12;
  localparam int VALUE_BITS  = 8;
  localparam int CFG_BITS    = 16;
  localparam int COUNT_BITS  = 24;
  localparam int REWARD_BITS = 40;
  localparam int TERM_BITS   = 25;
  localparam int DIV_BITS    = 32;
  localparam int APB_ADDR_BITS = 5;
  localparam int APB_DATA_BITS = 32;

  localparam logic [PIX_BITS-1:0] COORD_MASK = PIX_BITS'((64'd1 << COORD_BITS) - 64'd1);
  localparam logic [22:0] EXP_M1_Q24 = 23'd6171993;
  localparam logic [3:0]  SERIES_TERMS = 4'd9;

  localparam logic [2:0] REG_CENTER_X   = 3'd0;
  localparam logic [2:0] REG_CENTER_Y   = 3'd1;
  localparam logic [2:0] REG_COS_THETA  = 3'd2;
  localparam logic [2:0] REG_SIN_THETA  = 3'd3;
  localparam logic [2:0] REG_HALF_SIZE  = 3'd4;
  localparam logic [2:0] REG_DECAY      = 3'd5;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_PROJ, OP_RDIV_INIT, OP_DIV_STEP, OP_SQR, OP_EXP,
    OP_TMUL, OP_TDIV, OP_TACC, OP_WINIT, OP_NPOW, OP_ACC, OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] step;
    logic [3:0] k;
  } dp_cmd_t;

  typedef struct packed {
    logic nonzero;
    logic in_win;
    logic last;
    logic n_zero;
  } dp_status_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] center_x;
    logic [CFG_BITS-1:0] center_y;
    logic [CFG_BITS-1:0] cos_theta;
    logic [CFG_BITS-1:0] sin_theta;
    logic [CFG_BITS-1:0] half_size;
    logic [CFG_BITS-1:0] decay;
  } cfg_t;

endpackage
`default_nettype wire

// ===== hdl/owes_dp.sv =====
// datapath: projection, restoring divider for the radius, gaussian weight, accumulators
// depends on owes_pkg
`default_nettype none
module owes_dp import owes_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire dp_cmd_t                cmd_i,
  input  wire cfg_t                   cfg_i,
  input  wire logic [PIX_BITS-1:0]    pixel_x_i,
  input  wire logic [PIX_BITS-1:0]    pixel_y_i,
  input  wire logic [VALUE_BITS-1:0]  pixel_value_i,
  input  wire logic                   last_pixel_i,
  output dp_status_t                  status_o,
  output logic [REWARD_BITS-1:0]      total_reward_o,
  output logic [COUNT_BITS-1:0]       inside_count_o
);

  localparam int SH = 24 - WEIGHT_FRAC_BITS;
  localparam logic [25:0] RND = (SH > 0) ? (26'd1 << ((SH > 0) ? SH - 1 : 0)) : 26'd0;
  localparam logic [WEIGHT_FRAC_BITS-1:0] WMAX = '1;

  logic signed [16:0] dx_q, dy_q;
  logic signed [33:0] along_q, dist_q;
  logic [DIV_BITS-1:0] num_q;
  logic [15:0] rem_q, den_q;
  logic [16:0] r2_q;
  logic [4:0]  n_q;
  logic [15:0] f_q;
  logic [TERM_BITS-1:0] term_q, w_q;
  logic signed [26:0] sum_q;
  logic nz_q, last_q;
  logic [ACC_BITS-1:0]    acc_q;
  logic [COUNT_BITS-1:0]  cnt_q;
  logic [REWARD_BITS-1:0] reward_q;
  logic [COUNT_BITS-1:0]  count_q;

  logic [15:0] hs;
  logic [33:0] lim, along_abs, dist_abs;
  logic signed [16:0] ma;
  logic signed [15:0] mb;
  logic signed [32:0] prod;
  logic [16:0] dt;
  logic dge;
  logic [33:0] rsq;
  logic [32:0] ep;
  logic [40:0] tp;
  logic [29:0] recip;
  logic [54:0] qp;
  logic [47:0] wsum;
  logic [25:0] wr;
  logic [WEIGHT_FRAC_BITS-1:0] wt;
  logic [ACC_BITS:0] asum;
  logic [63:0] acc64;
  logic [PIX_BITS-1:0] pxm, pym;

  // ceil(2^29 / k): exact floor division for terms below 2^25
  always_comb begin
    unique case (cmd_i.k)
      4'd1:    recip = 30'd536870912;
      4'd2:    recip = 30'd268435456;
      4'd3:    recip = 30'd178956971;
      4'd4:    recip = 30'd134217728;
      4'd5:    recip = 30'd107374183;
      4'd6:    recip = 30'd89478486;
      4'd7:    recip = 30'd76695845;
      4'd8:    recip = 30'd67108864;
      4'd9:    recip = 30'd59652324;
      default: recip = '0;
    endcase
  end

  always_comb begin
    hs        = (cfg_i.half_size == '0) ? 16'd1 : cfg_i.half_size;
    lim       = {4'b0, hs, 14'b0};
    along_abs = along_q[33] ? 34'(-along_q) : 34'(along_q);
    dist_abs  = dist_q[33] ? 34'(-dist_q) : 34'(dist_q);
    unique case (cmd_i.step)
      2'd0: begin ma = dx_q; mb = $signed(cfg_i.cos_theta); end
      2'd1: begin ma = dy_q; mb = $signed(cfg_i.sin_theta); end
      2'd2: begin ma = dy_q; mb = $signed(cfg_i.cos_theta); end
      default: begin ma = dx_q; mb = $signed(cfg_i.sin_theta); end
    endcase
    prod = ma * mb;
    dt   = {rem_q, num_q[DIV_BITS-1]};
    dge  = dt >= {1'b0, den_q};
    rsq  = {17'b0, num_q[16:0]} * {17'b0, num_q[16:0]};
    ep   = {17'b0, cfg_i.decay} * {16'b0, r2_q};
    tp   = {16'b0, term_q} * {25'b0, f_q};
    qp   = {30'b0, num_q[TERM_BITS-1:0]} * {25'b0, recip};
    wsum = {23'b0, w_q} * {25'b0, EXP_M1_Q24} + 48'h80_0000;
    wr   = ({1'b0, w_q} + RND) >> SH;
    wt   = (wr > 26'(WMAX)) ? WMAX : wr[WEIGHT_FRAC_BITS-1:0];
    asum = {1'b0, acc_q} + (ACC_BITS+1)'(wt);
    acc64 = 64'(acc_q);
    pxm  = pixel_x_i & COORD_MASK;
    pym  = pixel_y_i & COORD_MASK;
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        dx_q   <= $signed({1'b0, pxm, 4'b0}) - $signed({1'b0, cfg_i.center_x});
        dy_q   <= $signed({1'b0, pym, 4'b0}) - $signed({1'b0, cfg_i.center_y});
        nz_q   <= pixel_value_i != '0;
        last_q <= last_pixel_i;
      end
      OP_PROJ: begin
        unique case (cmd_i.step)
          2'd0: along_q <= 34'(prod);
          2'd1: along_q <= along_q + 34'(prod);
          2'd2: dist_q  <= 34'(prod);
          default: dist_q <= dist_q - 34'(prod);
        endcase
      end
      OP_RDIV_INIT: begin
        num_q <= {dist_abs[29:0], 2'b0};
        rem_q <= '0;
        den_q <= hs;
      end
      OP_DIV_STEP: begin
        num_q <= {num_q[DIV_BITS-2:0], dge};
        rem_q <= dge ? 16'(dt - {1'b0, den_q}) : dt[15:0];
      end
      OP_SQR: r2_q <= rsq[32:16];
      OP_EXP: begin
        n_q    <= ep[32:28];
        f_q    <= ep[27:12];
        term_q <= TERM_BITS'(25'd1 << 24);
        sum_q  <= 27'sd16777216;
      end
      OP_TMUL: num_q <= DIV_BITS'(tp[40:16]);
      OP_TDIV: num_q <= DIV_BITS'(qp[53:29]);
      OP_TACC: begin
        term_q <= num_q[TERM_BITS-1:0];
        if (cmd_i.k[0]) sum_q <= sum_q - $signed({2'b0, num_q[TERM_BITS-1:0]});
        else            sum_q <= sum_q + $signed({2'b0, num_q[TERM_BITS-1:0]});
      end
      OP_WINIT: w_q <= (sum_q > 27'sd0) ? sum_q[TERM_BITS-1:0] : '0;
      OP_NPOW: begin
        w_q <= {1'b0, wsum[47:24]};
        n_q <= n_q - 5'd1;
      end
      OP_EMIT: begin
        reward_q <= (acc64 > 64'hFF_FFFF_FFFF) ? '1 : acc64[REWARD_BITS-1:0];
        count_q  <= cnt_q;
      end
      default: ;
    endcase
  end

  // running sums are architectural state and reset to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.op == OP_ACC) begin
      acc_q <= asum[ACC_BITS] ? '1 : asum[ACC_BITS-1:0];
      if (cnt_q != '1) cnt_q <= cnt_q + 1'b1;
    end else if (cmd_i.op == OP_EMIT) begin
      acc_q <= '0;
      cnt_q <= '0;
    end
  end

  assign status_o.nonzero = nz_q;
  assign status_o.in_win  = (along_abs <= lim) && (dist_abs <= lim);
  assign status_o.last    = last_q;
  assign status_o.n_zero  = n_q == '0;
  assign total_reward_o   = reward_q;
  assign inside_count_o   = count_q;

endmodule
`default_nettype wire

// ===== hdl/owes_ctrl.sv =====
// controller: sequences the datapath per pixel and owns the handshakes
// depends on owes_pkg
`default_nettype none
module owes_ctrl import owes_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_PROJ, ST_CHECK, ST_RDIV, ST_SQR, ST_EXP, ST_TMUL, ST_TDIV,
    ST_TACC, ST_WINIT, ST_NPOW, ST_ACC, ST_FIN
  } state_e;

  state_e     state_q;
  logic [4:0] cnt_q;
  logic [3:0] k_q;
  logic       out_valid_q;

  always_comb begin
    cmd_o.op   = OP_NONE;
    cmd_o.step = cnt_q[1:0];
    cmd_o.k    = k_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) cmd_o.op = OP_LOAD;
      ST_PROJ:  cmd_o.op = OP_PROJ;
      ST_CHECK: if (status_i.nonzero && status_i.in_win) cmd_o.op = OP_RDIV_INIT;
      ST_RDIV:  cmd_o.op = OP_DIV_STEP;
      ST_SQR:   cmd_o.op = OP_SQR;
      ST_EXP:   cmd_o.op = OP_EXP;
      ST_TMUL:  cmd_o.op = OP_TMUL;
      ST_TDIV:  cmd_o.op = OP_TDIV;
      ST_TACC:  cmd_o.op = OP_TACC;
      ST_WINIT: cmd_o.op = OP_WINIT;
      ST_NPOW:  if (!status_i.n_zero) cmd_o.op = OP_NPOW;
      ST_ACC:   cmd_o.op = OP_ACC;
      ST_FIN:   if (status_i.last && !(out_valid_q && out_stall_i)) cmd_o.op = OP_EMIT;
      default:  cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && cmd_o.op != OP_EMIT) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: if (in_valid_i) begin
          state_q <= ST_PROJ;
          cnt_q   <= '0;
        end
        ST_PROJ: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q[1:0] == 2'd3) state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          cnt_q   <= '0;
          state_q <= (status_i.nonzero && status_i.in_win) ? ST_RDIV : ST_FIN;
        end
        ST_RDIV: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) state_q <= ST_SQR;
        end
        ST_SQR: state_q <= ST_EXP;
        ST_EXP: begin
          k_q     <= 4'd1;
          state_q <= ST_TMUL;
        end
        ST_TMUL: state_q <= ST_TDIV;
        ST_TDIV: state_q <= ST_TACC;
        ST_TACC: begin
          if (k_q == SERIES_TERMS) state_q <= ST_WINIT;
          else begin
            k_q     <= k_q + 4'd1;
            state_q <= ST_TMUL;
          end
        end
        ST_WINIT: state_q <= ST_NPOW;
        ST_NPOW:  if (status_i.n_zero) state_q <= ST_ACC;
        ST_ACC:   state_q <= ST_FIN;
        ST_FIN: begin
          if (!status_i.last) state_q <= ST_IDLE;
          else if (!(out_valid_q && out_stall_i)) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block idle right after accepting a pixel");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_EMIT) |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten while held");
  a_series_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TACC) |-> (k_q >= 4'd1 && k_q <= SERIES_TERMS))
    else $error("series term index out of range");
  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_EMIT) |=> out_valid_o)
    else $error("emitted result not presented");
`endif

endmodule
`default_nettype wire

// ===== hdl/oriented_window_edge_score_top.sv =====
// top level: register port, controller and datapath of the oriented window scorer
// depends on owes_pkg, owes_ctrl, owes_dp
`default_nettype none
// Scores edge pixels against a rotated square window. Each accepted pixel beat
// is worked one at a time: an accept state, the projection products on the shared
// multiplier, a check state and a finish state for a zero or outside pixel.
// A pixel inside the window also runs the bit-serial radius divider, a square
// and an exponent step, nine series terms of multiply, reciprocal divide and
// accumulate, a weight init step, one power step per whole unit of the
// exponent (0 to 31) and an accumulate step. The result beat is held in an
// output register, so the next image can start while it waits to be taken;
// a last pixel only waits if the previous result is still pending.
// The user must write configuration through the register port only while the
// block is idle; the block itself does not enforce this.
module oriented_window_edge_score_top import owes_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_BITS-1:0] paddr,
  input  wire logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0]      prdata,
  output logic                          pready,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [PIX_BITS-1:0]      pixel_x_i,
  input  wire logic [PIX_BITS-1:0]      pixel_y_i,
  input  wire logic [VALUE_BITS-1:0]    pixel_value_i,
  input  wire logic                     last_pixel_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [REWARD_BITS-1:0]        total_reward_o,
  output logic [COUNT_BITS-1:0]         inside_count_o
);

  cfg_t       cfg_q;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  // register file, indexes beyond the list are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x   <= 16'd0;
      cfg_q.center_y   <= 16'd0;
      cfg_q.cos_theta  <= 16'd16384;
      cfg_q.sin_theta  <= 16'd0;
      cfg_q.half_size  <= 16'd256;
      cfg_q.decay      <= 16'd4096;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CENTER_X:   cfg_q.center_x   <= pwdata[CFG_BITS-1:0];
        REG_CENTER_Y:   cfg_q.center_y   <= pwdata[CFG_BITS-1:0];
        REG_COS_THETA:  cfg_q.cos_theta  <= pwdata[CFG_BITS-1:0];
        REG_SIN_THETA:  cfg_q.sin_theta  <= pwdata[CFG_BITS-1:0];
        REG_HALF_SIZE:  cfg_q.half_size  <= pwdata[CFG_BITS-1:0];
        REG_DECAY:      cfg_q.decay      <= pwdata[CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      REG_CENTER_X:   prdata = APB_DATA_BITS'(cfg_q.center_x);
      REG_CENTER_Y:   prdata = APB_DATA_BITS'(cfg_q.center_y);
      REG_COS_THETA:  prdata = APB_DATA_BITS'(cfg_q.cos_theta);
      REG_SIN_THETA:  prdata = APB_DATA_BITS'(cfg_q.sin_theta);
      REG_HALF_SIZE:  prdata = APB_DATA_BITS'(cfg_q.half_size);
      REG_DECAY:      prdata = APB_DATA_BITS'(cfg_q.decay);
      default:        prdata = '0;
    endcase
  end

  owes_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  owes_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_i          (cfg_q),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .pixel_value_i  (pixel_value_i),
    .last_pixel_i   (last_pixel_i),
    .status_o       (status),
    .total_reward_o (total_reward_o),
    .inside_count_o (inside_count_o)
  );

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// testbench for oriented_window_edge_score_top: directed table, then random phases
// depends on owes_pkg and the block's rtl; a predictor computes the expected result beats, but for typed directed rows
`timescale 1ns / 100ps
module tb;
  import owes_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int DRAIN_CYCLES   = 420;   // longest pixel plus margin
  localparam int PHASE_ITEMS    = 180;
  localparam int NUM_PHASES     = 10;
  localparam longint unsigned SUM_MAX   = (64'd1 << ACC_BITS) - 1;
  localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 1;
  localparam longint unsigned EXP_M1    = 64'd6171993;

  typedef struct packed {
    logic [REWARD_BITS-1:0] reward;
    logic [COUNT_BITS-1:0]  count;
  } score_t;

  typedef struct {
    logic [PIX_BITS-1:0]   x;
    logic [PIX_BITS-1:0]   y;
    logic [VALUE_BITS-1:0] v;
    logic                  l;
    bit                    typed;
    score_t                want;
  } pixel_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [PIX_BITS-1:0] pixel_x_i = '0, pixel_y_i = '0;
  logic [VALUE_BITS-1:0] pixel_value_i = '0;
  logic last_pixel_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [REWARD_BITS-1:0] total_reward_o;
  logic [COUNT_BITS-1:0] inside_count_o;

  // mirrored registers and running sums of the predictor
  logic [CFG_BITS-1:0] m_cx, m_cy, m_cos, m_sin, m_half, m_decay;
  longint unsigned sum_acc, hit_acc;

  score_t pending_scores[$];
  int errors = 0;
  int idle_cnt = 0;
  bit in_gaps = 1'b1;
  bit out_gaps = 1'b1;
  int stall_left = 0;

  oriented_window_edge_score_top dut (.*);

  always #4 clk_i = ~clk_i;

  // exp(-e), e in unsigned Q.16, result in Q1.24
  function automatic longint unsigned exp_q24(longint unsigned e);
    longint unsigned f, n, term, w;
    longint s;
    f = e & 64'hFFFF;
    n = e >> 16;
    term = 64'd1 << 24;
    s = longint'(term);
    for (int k = 1; k <= 9; k++) begin
      term = ((term * f) >> 16) / k;
      if (k % 2 == 1) s -= longint'(term);
      else s += longint'(term);
    end
    w = (s > 0) ? longint'(s) : 0;
    for (longint unsigned i = 0; i < n; i++) w = (w * EXP_M1 + (64'd1 << 23)) >> 24;
    return w;
  endfunction

  // update the sums with one pixel; returns 1 when a score beat is due
  function automatic bit score_pixel(pixel_row_t p, output score_t res);
    longint unsigned hs, along, nrm, lim, r, r2, w;
    longint dx, dy, c, s, a, d;
    if (p.v != 0) begin
      hs = (m_half == 0) ? 1 : m_half;
      dx = longint'({p.x, 4'b0}) - longint'(m_cx);
      dy = longint'({p.y, 4'b0}) - longint'(m_cy);
      c = longint'($signed(m_cos));
      s = longint'($signed(m_sin));
      a = dx * c + dy * s;
      d = dy * c - dx * s;
      along = (a < 0) ? -a : a;
      nrm = (d < 0) ? -d : d;
      lim = hs << 14;
      if (along <= lim && nrm <= lim) begin
        r = (nrm << 2) / hs;
        r2 = (r * r) >> 16;
        w = exp_q24((longint'(m_decay) * r2) >> 12);
        w = (w + 128) >> 8;
        if (w > 65535) w = 65535;
        sum_acc = (sum_acc > SUM_MAX - w) ? SUM_MAX : sum_acc + w;
        if (hit_acc < COUNT_MAX) hit_acc++;
      end
    end
    res = '0;
    if (!p.l) return 1'b0;
    res.reward = sum_acc[REWARD_BITS-1:0];
    res.count = hit_acc[COUNT_BITS-1:0];
    sum_acc = 0;
    hit_acc = 0;
    return 1'b1;
  endfunction

  task automatic apb_write(logic [2:0] idx, logic [CFG_BITS-1:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= APB_ADDR_BITS'({idx, 2'b00});
    pwdata <= {16'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_CENTER_X:   m_cx = val;
      REG_CENTER_Y:   m_cy = val;
      REG_COS_THETA:  m_cos = val;
      REG_SIN_THETA:  m_sin = val;
      REG_HALF_SIZE:  m_half = val;
      REG_DECAY:      m_decay = val;
      default: ;
    endcase
  endtask

  task automatic write_window(logic [15:0] cx, cy, cs, sn, hf, dc);
    apb_write(REG_CENTER_X, cx);
    apb_write(REG_CENTER_Y, cy);
    apb_write(REG_COS_THETA, cs);
    apb_write(REG_SIN_THETA, sn);
    apb_write(REG_HALF_SIZE, hf);
    apb_write(REG_DECAY, dc);
  endtask

  // drive one pixel beat and wait until it is taken
  task automatic send_pixel(pixel_row_t p);
    int gap;
    score_t res;
    gap = in_gaps ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_x_i <= p.x;
    pixel_y_i <= p.y;
    pixel_value_i <= p.v;
    last_pixel_i <= p.l;
    do @(posedge clk_i); while (in_stall_o);
    if (score_pixel(p, res)) pending_scores.push_back(p.typed ? p.want : res);
  endtask

  // block must be idle: all scores out and any trailing pixel finished
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic pixel_row_t random_pixel;
    pixel_row_t p;
    int span, cxp, cyp, xv, yv;
    p = '{default: '0};
    if ($urandom_range(0, 3) != 0) begin
      // mostly near the centre so that the window is actually hit
      span = (((m_half == 0) ? 1 : int'(m_half)) >> 4) + 3;
      cxp = int'(m_cx) >> 4;
      cyp = int'(m_cy) >> 4;
      xv = cxp + $urandom_range(0, 2 * span) - span;
      yv = cyp + $urandom_range(0, 2 * span) - span;
      p.x = PIX_BITS'((xv < 0) ? 0 : (xv > 4095) ? 4095 : xv);
      p.y = PIX_BITS'((yv < 0) ? 0 : (yv > 4095) ? 4095 : yv);
    end else begin
      p.x = PIX_BITS'($urandom_range(0, 4095));
      p.y = PIX_BITS'($urandom_range(0, 4095));
    end
    case ($urandom_range(0, 19))
      0, 1, 2: p.v = 0;
      3:       p.v = 8'hFF;
      default: p.v = VALUE_BITS'($urandom_range(1, 255));
    endcase
    p.l = ($urandom_range(0, 9) == 0);
    return p;
  endfunction

  function automatic logic [15:0] rand_trig;
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  // result side: random stall per beat, compare against the oldest expectation
  always @(posedge clk_i) begin
    score_t want;
    if (out_valid_o && !out_stall_i) begin
      if (pending_scores.size() == 0) begin
        $display("%0t: unexpected score beat, expected none, actual reward=%0d count=%0d",
                 $time, total_reward_o, inside_count_o);
        errors++;
      end else begin
        want = pending_scores.pop_front();
        if (total_reward_o !== want.reward) begin
          $display("%0t: total_reward expected %0d actual %0d", $time,
                   want.reward, total_reward_o);
          errors++;
        end
        if (inside_count_o !== want.count) begin
          $display("%0t: inside_count expected %0d actual %0d", $time,
                   want.count, inside_count_o);
          errors++;
        end
      end
      stall_left = out_gaps ? $urandom_range(0, 7) : 0;
    end
    out_stall_i <= (stall_left != 0);
    if (stall_left > 0) stall_left--;
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    pixel_row_t dir_rows[$];
    pixel_row_t p;
    m_cx = 16'd0; m_cy = 16'd0; m_cos = 16'd16384; m_sin = 16'd0;
    m_half = 16'd256; m_decay = 16'd4096;
    sum_acc = 0; hit_acc = 0;

    // directed rows under the reset window (centre 0, 16 pixel half size)
    dir_rows = '{
      '{12'd0, 12'd0, 8'd1, 1'b1, 1'b1, '{40'd65535, 24'd1}},       // centre, full weight
      '{12'd4095, 12'd4095, 8'd255, 1'b1, 1'b1, '{40'd0, 24'd0}},  // far corner
      '{12'd0, 12'd0, 8'd0, 1'b1, 1'b1, '{40'd0, 24'd0}},          // last with zero value
      '{12'd1, 12'd0, 8'd255, 1'b0, 1'b0, '{40'd0, 24'd0}},
      '{12'd0, 12'd1, 8'd8, 1'b0, 1'b0, '{40'd0, 24'd0}},
      '{12'd16, 12'd0, 8'd1, 1'b0, 1'b0, '{40'd0, 24'd0}},         // on the edge along axis
      '{12'd17, 12'd0, 8'd1, 1'b0, 1'b0, '{40'd0, 24'd0}},         // just outside
      '{12'd0, 12'd16, 8'd1, 1'b1, 1'b0, '{40'd0, 24'd0}},         // on the edge across
      '{12'd4095, 12'd0, 8'd1, 1'b0, 1'b0, '{40'd0, 24'd0}},
      '{12'd0, 12'd4095, 8'd128, 1'b0, 1'b0, '{40'd0, 24'd0}},
      '{12'd8, 12'd8, 8'd200, 1'b0, 1'b0, '{40'd0, 24'd0}},
      '{12'd15, 12'd15, 8'd2, 1'b1, 1'b0, '{40'd0, 24'd0}}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_pixel(dir_rows[i]);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        0: write_window(16'd0, 16'd0, 16'd16384, 16'd0, 16'd256, 16'd4096);
        // extremes: far corner, tiny window, steepest decay
        1: write_window(16'hFFFF, 16'hFFFF, -16'sd16384, 16'd16384, 16'd1, 16'hFFFF);
        // zero half size acts as one sixteenth pixel, no decay
        2: write_window(16'h8000, 16'h8000, 16'd0, -16'sd16384, 16'd0, 16'd0);
        // huge window, unnormalized direction
        3: write_window(16'h4000, 16'h2000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'd12000);
        default: write_window(CFG_BITS'($urandom_range(0, 65535)),
                              CFG_BITS'($urandom_range(0, 65535)),
                              rand_trig(), rand_trig(),
                              CFG_BITS'($urandom_range(16, 1024)),
                              CFG_BITS'($urandom_range(0, 65535)));
      endcase
      in_gaps = ($urandom_range(0, 3) != 0);
      out_gaps = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        p = random_pixel();
        if (i == PHASE_ITEMS - 1) p.l = 1'b1;
        send_pixel(p);
      end
    end

    drain();
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
